// ===== hw/rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Types, sizes and codes shared by the sorted set table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [IDX_W-1:0]    idx_t;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_CONTAINS = 2'd1,
		OP_READ     = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]   cmd;
		logic signed [31:0] key;
		logic [5:0]   position;
	} in_word_t;

	typedef struct packed {
		logic         found;
		logic [6:0]   where;
		logic signed [31:0] value;
		logic [6:0]   entries;
		logic [1:0]   status;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input word, start search bounds
		logic srch_rd;   // read slot at midpoint
		logic srch_upd;  // narrow bounds from read data
		logic sh_rd;     // read slot ptr-1
		logic sh_wr;     // write read data to slot ptr, step ptr down
		logic put;       // write key at lower bound, bump count
		logic rd_pos;    // read slot at requested position
		logic clear;     // empty the set
		logic emit;      // load result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic search_done;
		logic shift_done;
		logic hit;
		logic full;
		logic pos_ok;
		logic out_free;
	} dp_stat_t;

	// Low KEY_BITS bits of the 32-bit key field, zero padded if wider.
	function automatic key_t to_key(input logic [31:0] k);
		logic [KEY_BITS+31:0] ext;
		ext = {{KEY_BITS{1'b0}}, k};
		return ext[KEY_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_set_table.sv =====
// ----------------------------------------------------------------------------
// sorted_set_table
// Ascending set of signed keys without duplicates, held in a single RAM.
// ----------------------------------------------------------------------------
// Sequence, from the word taken to out_valid: contains runs a binary search
//   over the n stored keys, each probe a read of the registered RAM and then
//   a compare; insert then moves each entry above the slot up by one and
//   writes the key; read-at reads the slot unless past the count; clear empties.
// Throughput: one word at a time; the next word is taken once the result is
//   in the output register, which holds it while out_stall is high.
// Reset: count cleared, output empty; stored keys are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_table
	import sst_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_word_t in_word,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_word_t     out_word
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	sst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/sst_ram.sv =====
// ----------------------------------------------------------------------------
// sst_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sst_dp.sv =====
// ----------------------------------------------------------------------------
// sst_dp
// Datapath: key store, search bounds, shift pointer, count and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_dp
	import sst_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_word_t  in_word,
	input  wire dp_cmd_t   cmd,
	output dp_stat_t       stat,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_word
);

	op_t        op_q;
	key_t       key_q;
	logic [5:0] pos_q;
	cnt_t       fill_q;
	cnt_t       lo_q, hi_q, ptr_q;
	logic       eq_q;
	logic       full_q;
	logic       out_valid_q;
	out_word_t  out_q;

	logic [CNT_W:0] mid_sum;
	cnt_t           mid;
	cnt_t           ptr_dn;
	logic           pos_ok;
	logic           ram_wr_en, ram_rd_en;
	idx_t           ram_wr_addr, ram_rd_addr;
	key_t           ram_wr_data, ram_rd_data;
	out_word_t      res;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];
	assign ptr_dn  = ptr_q - cnt_t'(1);
	assign pos_ok  = (CNT_W + 6)'(pos_q) < (CNT_W + 6)'(fill_q);

	always_comb begin
		ram_rd_en   = cmd.srch_rd | cmd.sh_rd | cmd.rd_pos;
		ram_rd_addr = idx_t'(mid);
		if (cmd.sh_rd) begin
			ram_rd_addr = idx_t'(ptr_dn);
		end else if (cmd.rd_pos) begin
			ram_rd_addr = idx_t'(pos_q);
		end
		ram_wr_en   = cmd.sh_wr | cmd.put;
		ram_wr_addr = cmd.put ? idx_t'(lo_q) : idx_t'(ptr_q);
		ram_wr_data = cmd.put ? key_q : ram_rd_data;
	end

	sst_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(CAPACITY)
	) u_keys (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// search bounds, shift pointer and item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(in_word.cmd);
			key_q  <= to_key(in_word.key);
			pos_q  <= in_word.position;
			lo_q   <= '0;
			hi_q   <= fill_q;
			ptr_q  <= fill_q;
			eq_q   <= 1'b0;
			full_q <= fill_q >= cnt_t'(CAPACITY);
		end else begin
			if (cmd.srch_upd) begin
				if ($signed(ram_rd_data) < $signed(key_q)) begin
					lo_q <= mid + cnt_t'(1);
				end else begin
					hi_q <= mid;
					eq_q <= ram_rd_data == key_q;
				end
			end
			if (cmd.sh_wr) begin
				ptr_q <= ptr_dn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.clear) begin
			fill_q <= '0;
		end else if (cmd.put) begin
			fill_q <= fill_q + cnt_t'(1);
		end
	end

	always_comb begin
		res         = '0;
		res.entries = 7'(fill_q);
		res.status  = ST_OK;
		unique case (op_q)
			OP_INSERT, OP_CONTAINS: begin
				res.found = eq_q;
				res.where = 7'(lo_q);
				if (op_q == OP_INSERT) begin
					if (eq_q) begin
						res.status = ST_DUP;
					end else if (full_q) begin
						res.status = ST_FULL;
					end
				end
			end
			OP_READ: begin
				if (pos_ok) begin
					res.found = 1'b1;
					res.value = 32'(ram_rd_data);
				end else begin
					res.status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign stat.op          = op_q;
	assign stat.search_done = lo_q == hi_q;
	assign stat.shift_done  = ptr_q == lo_q;
	assign stat.hit         = eq_q;
	assign stat.full        = full_q;
	assign stat.pos_ok      = pos_ok;
	assign stat.out_free    = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

// ===== hw/rtl/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: binary search, shift-up for insert, read, clear and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ctrl
	import sst_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT,
		S_SHIFT_WR,
		S_READ,
		S_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_INSERT, OP_CONTAINS: state_d = S_SRCH_RD;
					OP_READ: state_d = stat.pos_ok ? S_READ : S_FINISH;
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_FINISH;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_SRCH_RD: begin
				if (stat.search_done) begin
					if (stat.op == OP_INSERT && !stat.hit && !stat.full) begin
						state_d = S_SHIFT;
					end else begin
						state_d = S_FINISH;
					end
				end else begin
					cmd.srch_rd = 1'b1;
					state_d     = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				cmd.srch_upd = 1'b1;
				state_d      = S_SRCH_RD;
			end
			S_SHIFT: begin
				if (stat.shift_done) begin
					cmd.put = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SHIFT;
			end
			S_READ: begin
				cmd.rd_pos = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

endmodule

`default_nettype wire

// ===== bench/tb_sorted_set_table.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_set_table
// Self-checking bench for the sorted set table. A queue of command words is
// built up front (directed corner cases, then runs that fill the set to
// capacity and mixed runs over a narrow key range). A clocked driver offers
// the words with random gaps. The set is mirrored in the bench when each
// word is taken, and every result word is checked against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_set_table
	import sst_pkg::*;
();

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;

	sorted_set_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mirror of the stored set
	logic signed [31:0] set_keys [CAPACITY];
	int                 set_fill = 0;

	in_word_t  queued_words [$];
	out_word_t pending_results [$];
	int        n_taken = 0;
	int        n_checked = 0;
	int        n_bad = 0;
	int        hold_left = 0;
	int        next_hold_at = 400;

	function automatic out_word_t apply_to_set(input in_word_t w);
		out_word_t          r;
		int                 lb;
		logic signed [31:0] k;
		r = '0;
		k = w.key;
		case (op_t'(w.cmd))
			OP_INSERT, OP_CONTAINS: begin
				lb = 0;
				while (lb < set_fill && set_keys[lb] < k)
					lb++;
				r.where = 7'(lb);
				r.found = (lb < set_fill) && (set_keys[lb] == k);
				if (op_t'(w.cmd) == OP_INSERT) begin
					if (r.found) begin
						r.status = ST_DUP;
					end else if (set_fill >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						for (int i = set_fill; i > lb; i--)
							set_keys[i] = set_keys[i-1];
						set_keys[lb] = k;
						set_fill++;
					end
				end
			end
			OP_READ: begin
				if (int'(w.position) < set_fill) begin
					r.found = 1'b1;
					r.value = set_keys[w.position];
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: set_fill = 0;
		endcase
		r.entries = 7'(set_fill);
		return r;
	endfunction

	task automatic queue_word(input op_t op, input logic [31:0] k, input logic [31:0] pos);
		in_word_t w;
		w.cmd = op;
		w.key = k;
		w.position = 6'(pos);
		queued_words.push_back(w);
	endtask

	// mostly a narrow range around zero so that hits and duplicates are common
	function automatic logic [31:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 32'(int'($urandom_range(0, 80)) - 40);
		else if (sel == 6)
			return 32'h8000_0000 + $urandom_range(0, 3);
		else if (sel == 7)
			return 32'h7fff_ffff - $urandom_range(0, 3);
		return $urandom;
	endfunction

	function automatic int draw_wait(input bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	// driver: predicts on acceptance, then offers the next word after a gap
	int tx_wait = 0;
	bit tx_quiet = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		in_word_t nw;
		logic     nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
			tx_wait = 0;
		end else begin
			nv = in_valid;
			nw = in_word;
			if (in_valid && !in_stall) begin
				pending_results.push_back(apply_to_set(in_word));
				n_taken++;
				nv = 1'b0;
				if ($urandom_range(0, 49) == 0)
					tx_quiet = !tx_quiet;
				tx_wait = draw_wait(tx_quiet);
			end
			if (!nv) begin
				if (tx_wait > 0) begin
					tx_wait--;
				end else if (queued_words.size() > 0) begin
					nw = queued_words.pop_front();
					nv = 1'b1;
				end
			end
			in_valid <= nv;
			in_word <= nw;
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			next_hold_at <= 400;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (n_taken >= next_hold_at) begin
			hold_left <= 600;
			next_hold_at <= next_hold_at + 700;
		end
	end

	// monitor: checks each taken result word against the oldest prediction
	int rx_wait = 0;
	bit rx_quiet = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_word;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display({"unexpected result word: found=%0b where=%0d",
							" value=%0d entries=%0d status=%0d"},
							out_word.found, out_word.where, out_word.value,
							out_word.entries, out_word.status);
				end else begin
					exp_word = pending_results.pop_front();
					if (out_word !== exp_word) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"result %0d: expected found=%0b where=%0d",
								" value=%0d entries=%0d status=%0d, got found=%0b",
								" where=%0d value=%0d entries=%0d status=%0d"},
								n_checked, exp_word.found, exp_word.where,
								exp_word.value, exp_word.entries, exp_word.status,
								out_word.found, out_word.where, out_word.value,
								out_word.entries, out_word.status);
					end
				end
				n_checked++;
				if ($urandom_range(0, 49) == 0)
					rx_quiet = !rx_quiet;
				rx_wait = draw_wait(rx_quiet);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_stall <= (rx_wait > 0) || (hold_left > 0);
		end
	end

	initial begin
		#(25_000_000);
		$display("sorted_set_table test failed");
		$finish;
	end

	initial begin
		logic [31:0] block_keys [$];
		int          n_words;
		int          blk_len;
		int unsigned r;

		// directed: empty set, extremes, duplicate, misses, range, clear
		queue_word(OP_CONTAINS, 32'h0, $urandom);
		queue_word(OP_READ, $urandom, 32'd0);
		queue_word(OP_READ, $urandom, 32'd63);
		queue_word(OP_INSERT, 32'h0, $urandom);
		queue_word(OP_INSERT, 32'h7fff_ffff, $urandom);
		queue_word(OP_INSERT, 32'h8000_0000, $urandom);
		queue_word(OP_INSERT, 32'hffff_ffff, $urandom);
		queue_word(OP_INSERT, 32'h1, $urandom);
		queue_word(OP_INSERT, 32'h0, $urandom);
		queue_word(OP_CONTAINS, 32'h8000_0000, $urandom);
		queue_word(OP_CONTAINS, 32'h7fff_ffff, $urandom);
		queue_word(OP_CONTAINS, 32'h5, $urandom);
		queue_word(OP_CONTAINS, 32'h7fff_fffe, $urandom);
		queue_word(OP_READ, $urandom, 32'd0);
		queue_word(OP_READ, $urandom, 32'd4);
		queue_word(OP_READ, $urandom, 32'd5);
		queue_word(OP_CLEAR, $urandom, $urandom);
		queue_word(OP_READ, $urandom, 32'd0);
		queue_word(OP_CONTAINS, 32'hffff_ffff, $urandom);
		queue_word(OP_INSERT, 32'h7fff_ffff, $urandom);
		n_words = queued_words.size();

		while (n_words < 1800) begin
			if ($urandom_range(0, 3) == 0) begin
				// fill to capacity, then duplicates, refused keys and probes
				block_keys.delete();
				queue_word(OP_CLEAR, $urandom, $urandom);
				for (int i = 0; i < 72; i++) begin
					block_keys.push_back($urandom);
					queue_word(OP_INSERT, block_keys[i], $urandom);
				end
				for (int i = 0; i < 30; i++) begin
					r = $urandom_range(0, 2);
					if (r == 0)
						queue_word(OP_INSERT, block_keys[$urandom_range(0, 71)], $urandom);
					else if (r == 1)
						queue_word(OP_CONTAINS, block_keys[$urandom_range(0, 71)], $urandom);
					else
						queue_word(OP_READ, $urandom, $urandom);
				end
				n_words += 103;
			end else begin
				blk_len = $urandom_range(60, 200);
				for (int i = 0; i < blk_len; i++) begin
					r = $urandom_range(0, 99);
					if (r < 45)
						queue_word(OP_INSERT, pick_key(), $urandom);
					else if (r < 72)
						queue_word(OP_CONTAINS, pick_key(), $urandom);
					else if (r < 97)
						queue_word(OP_READ, $urandom,
							r[0] ? $urandom_range(0, 15) : $urandom);
					else
						queue_word(OP_CLEAR, $urandom, $urandom);
				end
				n_words += blk_len;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (queued_words.size() > 0 || in_valid)
			@(posedge clk);
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (n_bad == 0 && pending_results.size() == 0)
			$display("sorted_set_table test passed");
		else
			$display("sorted_set_table test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sst_dp.sv
hw/rtl/sst_ctrl.sv
hw/rtl/sorted_set_table.sv
bench/tb_sorted_set_table.sv
